>>> rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Queue depth, count width and field widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 16;

  // Operation codes
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // One stored slot
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;    // insert the new entry this cycle
    logic   rem;    // remove the front entry this cycle
    entry_t entry;  // the entry being inserted
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/spq_if.sv
`default_nettype none

// Request channel
interface spq_in_if;
  logic                                   valid;
  logic                                   ready;
  spq_pkg::op_t                           func;
  logic signed [spq_pkg::VALUE_W-1:0]     item_value;
  logic signed [spq_pkg::PRIO_W-1:0]      item_priority;

  modport source (output valid, func, item_value, item_priority, input ready);
  modport sink   (input valid, func, item_value, item_priority, output ready);
endinterface

// Status channel
interface spq_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [spq_pkg::VALUE_W-1:0]     front_value;
  logic signed [spq_pkg::VALUE_W-1:0]     rear_value;
  logic [spq_pkg::CNT_W-1:0]              entry_count;
  logic                                   is_empty;
  spq_pkg::err_t                          op_error;

  modport source (output valid, front_value, rear_value, entry_count, is_empty, op_error,
                  input ready);
  modport sink   (input valid, front_value, rear_value, entry_count, is_empty, op_error,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/spq_cell.sv
`default_nettype none

// One slot of the sorted chain. Holds an entry, compares it against the
// incoming priority and takes its neighbour's entry when the chain shifts.
module spq_cell (
  input  wire logic            clk,
  input  wire spq_pkg::ctrl_t  ctrl_i,
  input  wire logic            occ_i,        // slot currently holds an entry
  input  wire logic            left_keep_i,  // left neighbour keeps its entry
  input  wire spq_pkg::entry_t left_i,
  input  wire spq_pkg::entry_t right_i,
  output logic                 keep_o,
  output spq_pkg::entry_t      entry_o
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Stays put on insert when its priority is equal or higher
  assign keep_o  = occ_i && ($signed(entry_r.prio) >= $signed(ctrl_i.entry.prio));
  assign entry_o = entry_r;

  // Insert: new entry lands at the boundary, the rest move right.
  // Remove: everything moves left.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        entry_nxt = left_keep_i ? ctrl_i.entry : left_i;
      end
    end else if (ctrl_i.rem) begin
      entry_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/stable_priority_queue.sv
// Sorted-list priority queue built as a chain of compare-and-shift cells.
// An accepted transaction's status is held pending, then moves to the output stage.
// Throughput: one transaction per cycle unless the output stage stalls; insert or
// remove updates all cells at once, so the chain length does not affect the rate.
// Reset: synchronous, active low; clears the entry count and the output stage.
// Slot contents are not cleared; only occupied slots are ever reported.
`default_nettype none

module stable_priority_queue (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam int CAP = spq_pkg::CAPACITY;

  logic [spq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      pend_r;
  spq_pkg::err_t             err_r, err_nxt;
  logic                      move;
  logic                      accept;

  logic                      out_valid_r;
  logic signed [spq_pkg::VALUE_W-1:0] out_front_r, out_rear_r;
  logic [spq_pkg::CNT_W-1:0] out_count_r;
  logic                      out_empty_r;
  spq_pkg::err_t             out_err_r;

  spq_pkg::ctrl_t            ctrl;
  spq_pkg::entry_t           entries [CAP];
  logic [CAP-1:0]            keep;
  logic [CAP-1:0]            occ;
  logic [CAP-1:0]            rear_sel;
  logic signed [spq_pkg::VALUE_W-1:0] rear_value;
  logic                      is_full;
  logic                      is_empty_q;

  // Handshake: a pending status moves to the output stage when it is free
  assign move        = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || move;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_full    = (count_r == spq_pkg::CNT_W'(CAP));
  assign is_empty_q = (count_r == '0);

  // Operation decode
  always_comb begin
    ctrl.ins         = 1'b0;
    ctrl.rem         = 1'b0;
    ctrl.entry.value = in_ch.item_value;
    ctrl.entry.prio  = in_ch.item_priority;
    count_nxt        = count_r;
    err_nxt          = err_r;
    if (accept) begin
      case (in_ch.func)
        spq_pkg::OP_ENQ: begin
          if (is_full) begin
            err_nxt = spq_pkg::ERR_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + 1'b1;
            err_nxt   = spq_pkg::ERR_NONE;
          end
        end
        spq_pkg::OP_DEQ: begin
          if (is_empty_q) begin
            err_nxt = spq_pkg::ERR_EMPTY;
          end else begin
            ctrl.rem  = 1'b1;
            count_nxt = count_r - 1'b1;
            err_nxt   = spq_pkg::ERR_NONE;
          end
        end
        default: begin
          err_nxt = spq_pkg::ERR_NONE;
        end
      endcase
    end
  end

  // Cell chain
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_keep;

    assign occ[i] = (spq_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_e    = ctrl.entry;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_e    = entries[i-1];
      assign left_keep = keep[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign right_e     = '0;
      assign rear_sel[i] = occ[i];
    end else begin : g_mid
      assign right_e     = entries[i+1];
      assign rear_sel[i] = occ[i] && !occ[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .left_keep_i (left_keep),
      .left_i      (left_e),
      .right_i     (right_e),
      .keep_o      (keep[i]),
      .entry_o     (entries[i])
    );
  end

  // Rear entry: the one occupied slot whose right neighbour is free
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < CAP; i++) begin
      if (rear_sel[i]) begin
        rear_value = rear_value | entries[i].value;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Error code and output stage payload
  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    if (move) begin
      out_front_r <= is_empty_q ? '1 : entries[0].value;
      out_rear_r  <= is_empty_q ? '1 : rear_value;
      out_count_r <= count_r;
      out_empty_r <= is_empty_q;
      out_err_r   <= err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.rear_value  = out_rear_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.op_error    = out_err_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::CNT_W'(CAP))
    else $error("entry count beyond capacity");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    occ[1] |-> ($signed(entries[0].prio) >= $signed(entries[1].prio)))
    else $error("front pair out of priority order");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.func == spq_pkg::OP_ENQ && is_full) |=>
      (err_r == spq_pkg::ERR_FULL && count_r == spq_pkg::CNT_W'(CAP)))
    else $error("enqueue on full queue not dropped");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

>>> dv/tb_stable_priority_queue.sv
`timescale 1ns / 100ps

module tb_stable_priority_queue;

  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STALL_LEN = 64;
  localparam int MAX_GAP = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam logic signed [spq_pkg::VALUE_W-1:0] NO_ENTRY = '1;

  // Status expected after one transaction
  typedef struct packed {
    logic signed [spq_pkg::VALUE_W-1:0] front;
    logic signed [spq_pkg::VALUE_W-1:0] rear;
    logic [spq_pkg::CNT_W-1:0] count;
    logic empty;
    spq_pkg::err_t err;
  } status_t;

  logic clk;
  logic rst_n;

  spq_in_if in_ch();
  spq_out_if out_ch();

  stable_priority_queue dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the sorted list
  logic signed [spq_pkg::VALUE_W-1:0] pq_value [spq_pkg::CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0] pq_prio [spq_pkg::CAPACITY];
  int pq_count;

  status_t status_q [$];
  int mismatch_count = 0;
  int cycle_count;

  // Idle rates in percent, and the long output hold-off request
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Apply one operation to the shadow list and return the status it should report
  function automatic status_t next_status(spq_pkg::op_t op,
                                          logic signed [spq_pkg::VALUE_W-1:0] value,
                                          logic signed [spq_pkg::PRIO_W-1:0] prio);
    status_t s;
    int pos;
    int k;
    s.err = spq_pkg::ERR_NONE;
    if (op == spq_pkg::OP_ENQ) begin
      if (pq_count >= spq_pkg::CAPACITY) begin
        s.err = spq_pkg::ERR_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < pq_count && pq_prio[pos] >= prio) pos++;
        for (k = pq_count; k > pos; k--) begin
          pq_value[k] = pq_value[k-1];
          pq_prio[k] = pq_prio[k-1];
        end
        pq_value[pos] = value;
        pq_prio[pos] = prio;
        pq_count++;
      end
    end else if (pq_count == 0) begin
      s.err = spq_pkg::ERR_EMPTY;
    end else begin
      for (k = 1; k < pq_count; k++) begin
        pq_value[k-1] = pq_value[k];
        pq_prio[k-1] = pq_prio[k];
      end
      pq_count--;
    end
    s.front = (pq_count > 0) ? pq_value[0] : NO_ENTRY;
    s.rear = (pq_count > 0) ? pq_value[pq_count-1] : NO_ENTRY;
    s.count = pq_count[spq_pkg::CNT_W-1:0];
    s.empty = (pq_count == 0);
    return s;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Offer one transaction after a random gap; valid stays high for the next one
  task automatic send_item(spq_pkg::op_t op, logic signed [spq_pkg::VALUE_W-1:0] value,
                           logic signed [spq_pkg::PRIO_W-1:0] prio);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= op;
    in_ch.item_value <= value;
    in_ch.item_priority <= prio;
    do @(posedge clk); while (!in_ch.ready);
    status_q.push_back(next_status(op, value, prio));
  endtask

  // Empty queue, extremes of value and priority, ties, overflow, ignored fields
  task automatic test_corner_cases();
    logic signed [spq_pkg::VALUE_W-1:0] fill_val [spq_pkg::CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] fill_prio [spq_pkg::CAPACITY];
    int i;
    fill_val = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1, 32'sd2, 32'sd3,
                 32'sd4, 32'sh5555aaaa, 32'shaaaa5555, 32'sd10, 32'sd11, 32'sd12,
                 32'sd13, 32'sd14, 32'sd15};
    fill_prio = '{16'sd5, 16'sd5, 16'sh7fff, 16'sh8000, 16'sd5, 16'sd0, -16'sd1,
                  16'sh7fff, 16'sh8000, 16'sd0, 16'sd5, 16'sd100, -16'sd100, 16'sd1,
                  -16'sd1, 16'sd0};
    send_item(spq_pkg::OP_DEQ, 32'sh12345678, 16'sh1234);
    send_item(spq_pkg::OP_ENQ, 32'sh80000000, 16'sh8000);
    send_item(spq_pkg::OP_DEQ, '0, '0);
    for (i = 0; i < spq_pkg::CAPACITY; i++) begin
      send_item(spq_pkg::OP_ENQ, fill_val[i], fill_prio[i]);
    end
    send_item(spq_pkg::OP_ENQ, 32'sh7fffffff, 16'sh7fff);
    send_item(spq_pkg::OP_DEQ, 32'sh5a5a5a5a, 16'sh7fff);
    send_item(spq_pkg::OP_DEQ, '1, 16'sh8000);
    send_item(spq_pkg::OP_DEQ, 32'sha5a5a5a5, '1);
  endtask

  // Bursts leaning towards enqueue or dequeue so the list swings between full and empty
  task automatic test_random_traffic(int n_items, int in_pct, int out_pct);
    int sent;
    int burst_left;
    int enq_bias;
    spq_pkg::op_t op;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    in_idle_pct = in_pct;
    out_idle_pct <= out_pct;
    sent = 0;
    burst_left = 0;
    enq_bias = 50;
    while (sent < n_items) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0: enq_bias = 25;
          1: enq_bias = 50;
          default: enq_bias = 75;
        endcase
      end
      op = ($urandom_range(99) < enq_bias) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
      value = $urandom;
      // half the picks come from a narrow band of priorities so ties are common
      case ($urandom_range(3))
        0: prio = spq_pkg::PRIO_W'($urandom);
        3: prio = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        default: begin
          prio = $signed(spq_pkg::PRIO_W'($urandom_range(4))) - 16'sd2;
        end
      endcase
      send_item(op, value, prio);
      burst_left--;
      sent++;
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_stall();
    int i;
    in_idle_pct = 0;
    out_idle_pct <= 0;
    stall_req <= stall_req + 1;
    for (i = 0; i < 24; i++) begin
      send_item(($urandom_range(3) == 0) ? spq_pkg::OP_DEQ : spq_pkg::OP_ENQ, $urandom,
                spq_pkg::PRIO_W'($urandom));
    end
  endtask

  // Receiver ready: random, or low through a requested hold-off
  always @(posedge clk) begin
    if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      stall_left <= STALL_LEN - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Compare each status transaction with the oldest expectation
  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected status, expected none, got front %0d count %0d",
                 $time, out_ch.front_value, out_ch.entry_count);
        mismatch_count++;
      end else begin
        want = status_q.pop_front();
        check_field("front_value", want.front, out_ch.front_value);
        check_field("rear_value", want.rear, out_ch.rear_value);
        check_field("entry_count", want.count, out_ch.entry_count);
        check_field("is_empty", want.empty, out_ch.is_empty);
        check_field("op_error", want.err, out_ch.op_error);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Test sequence
  initial begin
    pq_count = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= spq_pkg::OP_ENQ;
    in_ch.item_value <= '0;
    in_ch.item_priority <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_random_traffic(650, 32, 80);
    test_random_traffic(650, 80, 32);
    test_random_traffic(650, 0, 0);
    test_output_stall();

    // let the last statuses drain
    in_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
dv/tb_stable_priority_queue.sv
